FILE: hdl/drc_pkg.sv
// shared types, codes and reset constants for the display refresh coalescer
package drc_pkg;

  localparam int MAX_SLOTS_DEF = 8;
  localparam int ACNT_W        = 4;
  localparam int TIME_W        = 32;
  localparam int SPAN_W        = 24;
  localparam int CFG_IDX_W     = 3;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_LAYOUT = 3'd2;
  localparam logic [2:0] CMD_INIT   = 3'd3;
  localparam logic [2:0] CMD_DONE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_QUIET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXDEF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MININT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAINT    = 3'd5;

  localparam logic [SPAN_W-1:0] QUIET_RST    = 24'd1500;
  localparam logic [SPAN_W-1:0] MAXDEF_RST   = 24'd4000;
  localparam logic [SPAN_W-1:0] MININT_RST   = 24'd10000;
  localparam logic [7:0]        PLIMIT_RST   = 8'd5;
  localparam logic [SPAN_W-1:0] PERIODIC_RST = 24'd360000;
  localparam logic [SPAN_W-1:0] MAINT_RST    = 24'd0;

  localparam logic [7:0] PCOUNT_SAT = 8'd255;

  typedef struct packed {
    logic [SPAN_W-1:0] quiet_delay_ms;
    logic [SPAN_W-1:0] max_defer_ms;
    logic [SPAN_W-1:0] min_interval_ms;
    logic [7:0]        partial_limit;
    logic [SPAN_W-1:0] periodic_full_ms;
    logic [SPAN_W-1:0] maintenance_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [TIME_W-1:0] now_ms;
    logic [7:0]        slot;
    logic [7:0]        requested_count;
    logic              was_full;
  } item_t;

  typedef struct packed {
    logic issue_refresh;
    logic issue_full;
    logic write_accepted;
    logic pending_now;
    logic busy_now;
  } result_t;

  // wrapping time difference against a span
  function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] stamp,
                                   input logic [SPAN_W-1:0] span);
    logic [TIME_W-1:0] diff;
    diff = now - stamp;
    return diff >= {{(TIME_W-SPAN_W){1'b0}}, span};
  endfunction

endpackage

FILE: hdl/drc_if.sv
// channel interfaces for items, results and register writes
interface drc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] now_ms;
  logic [7:0]  slot;
  logic [7:0]  requested_count;
  logic        was_full;

  modport source (output valid, command, now_ms, slot, requested_count, was_full,
                  input ready);
  modport sink (input valid, command, now_ms, slot, requested_count, was_full,
                output ready);
endinterface

interface drc_out_if;
  logic valid;
  logic ready;
  logic issue_refresh;
  logic issue_full;
  logic write_accepted;
  logic pending_now;
  logic busy_now;

  modport source (output valid, issue_refresh, issue_full, write_accepted, pending_now,
                  busy_now, input ready);
  modport sink (input valid, issue_refresh, issue_full, write_accepted, pending_now,
                busy_now, output ready);
endinterface

interface drc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/display_refresh_coalescer.sv
// top level: input register, decision engine, result register, configuration bank
// an accepted item waits in the input register, then its result is captured in the result register
// throughput: one item per cycle while out_ch.ready drains results, set by the single decision stage
// while a finished result waits, one more item fills an empty input register, then input stalls
// reset (rst_n low, synchronous) empties both registers and restores all state and
// configuration to their defaults; no clearing pass is needed
module display_refresh_coalescer #(
  parameter int MAX_SLOTS = drc_pkg::MAX_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  drc_in_if.sink   in_ch,
  drc_out_if.source out_ch,
  drc_cfg_if.sink  cfg_ch
);

  drc_pkg::cfg_t    cfg;
  drc_pkg::item_t   in_item_r;
  logic             in_vld_r, in_vld_nxt;
  drc_pkg::result_t res;
  drc_pkg::result_t out_res_r;
  logic             out_vld_r, out_vld_nxt;
  logic             adv;
  logic             take;

  // item leaves the input register when the result slot is free or being drained
  assign adv  = in_vld_r && (!out_vld_r || out_ch.ready);
  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !in_vld_r || adv;

  assign in_vld_nxt  = take || (in_vld_r && !adv);
  assign out_vld_nxt = adv || (out_vld_r && !out_ch.ready);

  drc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  drc_engine #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item_r.command         <= in_ch.command;
      in_item_r.now_ms          <= in_ch.now_ms;
      in_item_r.slot            <= in_ch.slot;
      in_item_r.requested_count <= in_ch.requested_count;
      in_item_r.was_full        <= in_ch.was_full;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.issue_refresh  = out_res_r.issue_refresh;
  assign out_ch.issue_full     = out_res_r.issue_full;
  assign out_ch.write_accepted = out_res_r.write_accepted;
  assign out_ch.pending_now    = out_res_r.pending_now;
  assign out_ch.busy_now       = out_res_r.busy_now;

endmodule

FILE: hdl/drc_cfg.sv
// configuration register bank
module drc_cfg (
  input  logic              clk,
  input  logic              rst_n,
  drc_cfg_if.sink           cfg_ch,
  output drc_pkg::cfg_t     cfg
);

  drc_pkg::cfg_t cfg_r;
  drc_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        drc_pkg::CFG_QUIET:    cfg_nxt.quiet_delay_ms   = cfg_ch.data;
        drc_pkg::CFG_MAXDEF:   cfg_nxt.max_defer_ms     = cfg_ch.data;
        drc_pkg::CFG_MININT:   cfg_nxt.min_interval_ms  = cfg_ch.data;
        drc_pkg::CFG_PLIMIT:   cfg_nxt.partial_limit    = cfg_ch.data[7:0];
        drc_pkg::CFG_PERIODIC: cfg_nxt.periodic_full_ms = cfg_ch.data;
        drc_pkg::CFG_MAINT:    cfg_nxt.maintenance_ms   = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quiet_delay_ms   <= drc_pkg::QUIET_RST;
      cfg_r.max_defer_ms     <= drc_pkg::MAXDEF_RST;
      cfg_r.min_interval_ms  <= drc_pkg::MININT_RST;
      cfg_r.partial_limit    <= drc_pkg::PLIMIT_RST;
      cfg_r.periodic_full_ms <= drc_pkg::PERIODIC_RST;
      cfg_r.maintenance_ms   <= drc_pkg::MAINT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hdl/drc_engine.sv
// scheduler state and per-item decision logic
module drc_engine #(
  parameter int MAX_SLOTS = drc_pkg::MAX_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  drc_pkg::item_t    item,
  input  drc_pkg::cfg_t     cfg,
  output drc_pkg::result_t  res
);

  localparam logic [7:0]                 MaxSlots8 = 8'(MAX_SLOTS);
  localparam logic [drc_pkg::ACNT_W-1:0] MaxSlotsA = drc_pkg::ACNT_W'(MAX_SLOTS);

  logic                        initialized_r, initialized_nxt;
  logic                        busy_r, busy_nxt;
  logic                        has_data_r, has_data_nxt;
  logic                        pending_r, pending_nxt;
  logic [drc_pkg::ACNT_W-1:0]  active_count_r, active_count_nxt;
  logic [drc_pkg::TIME_W-1:0]  first_update_time_r, first_update_time_nxt;
  logic [drc_pkg::TIME_W-1:0]  last_update_time_r, last_update_time_nxt;
  logic [drc_pkg::TIME_W-1:0]  last_refresh_time_r, last_refresh_time_nxt;
  logic [drc_pkg::TIME_W-1:0]  last_full_time_r, last_full_time_nxt;
  logic [7:0]                  partial_count_r, partial_count_nxt;

  logic wr_ok;
  logic sched;
  logic tick_go;
  logic per_on;
  logic per_due;
  logic fire;
  logic full;
  logic issue;

  assign wr_ok = (item.slot != 8'd0) &&
                 (item.slot <= {{(8-drc_pkg::ACNT_W){1'b0}}, active_count_r});
  assign sched = ((item.command == drc_pkg::CMD_WRITE) && wr_ok) ||
                 ((item.command == drc_pkg::CMD_LAYOUT) && has_data_r);
  assign tick_go = (item.command == drc_pkg::CMD_TICK) && initialized_r && !busy_r &&
                   has_data_r &&
                   drc_pkg::elapsed(item.now_ms, last_refresh_time_r, cfg.min_interval_ms);
  assign per_on  = cfg.periodic_full_ms != '0;
  assign per_due = per_on &&
                   drc_pkg::elapsed(item.now_ms, last_full_time_r, cfg.periodic_full_ms);

  always_comb begin
    fire = 1'b0;
    full = 1'b1;
    if (pending_r) begin
      fire = drc_pkg::elapsed(item.now_ms, last_update_time_r, cfg.quiet_delay_ms) ||
             drc_pkg::elapsed(item.now_ms, first_update_time_r, cfg.max_defer_ms);
      full = per_due || (partial_count_r >= cfg.partial_limit);
    end else if (per_on) begin
      fire = per_due;
    end else if (cfg.maintenance_ms != '0) begin
      fire = drc_pkg::elapsed(item.now_ms, last_refresh_time_r, cfg.maintenance_ms);
    end
  end

  assign issue = tick_go && fire;

  always_comb begin
    initialized_nxt       = initialized_r;
    busy_nxt              = busy_r;
    has_data_nxt          = has_data_r;
    pending_nxt           = pending_r;
    active_count_nxt      = active_count_r;
    first_update_time_nxt = first_update_time_r;
    last_update_time_nxt  = last_update_time_r;
    last_refresh_time_nxt = last_refresh_time_r;
    last_full_time_nxt    = last_full_time_r;
    partial_count_nxt     = partial_count_r;

    case (item.command)
      drc_pkg::CMD_WRITE: begin
        if (wr_ok) has_data_nxt = 1'b1;
      end
      drc_pkg::CMD_LAYOUT: begin
        if (item.requested_count == 8'd0) begin
          active_count_nxt = drc_pkg::ACNT_W'(1);
        end else if (item.requested_count > MaxSlots8) begin
          active_count_nxt = MaxSlotsA;
        end else begin
          active_count_nxt = item.requested_count[drc_pkg::ACNT_W-1:0];
        end
      end
      drc_pkg::CMD_TICK: begin
        if (issue) begin
          busy_nxt = 1'b1;
          if (pending_r) pending_nxt = 1'b0;
        end
      end
      drc_pkg::CMD_INIT: begin
        last_refresh_time_nxt = item.now_ms;
        last_full_time_nxt    = item.now_ms;
        partial_count_nxt     = 8'd0;
        initialized_nxt       = 1'b1;
        busy_nxt              = 1'b0;
      end
      drc_pkg::CMD_DONE: begin
        last_refresh_time_nxt = item.now_ms;
        if (item.was_full) begin
          last_full_time_nxt = item.now_ms;
          partial_count_nxt  = 8'd0;
        end else if (partial_count_r != drc_pkg::PCOUNT_SAT) begin
          partial_count_nxt = partial_count_r + 8'd1;
        end
        busy_nxt = 1'b0;
      end
      default: ;
    endcase

    // opening or extending a defer window
    if (sched) begin
      if (!pending_r) first_update_time_nxt = item.now_ms;
      last_update_time_nxt = item.now_ms;
      pending_nxt          = 1'b1;
    end
  end

  always_comb begin
    res.issue_refresh  = issue;
    res.issue_full     = issue && full;
    res.write_accepted = (item.command == drc_pkg::CMD_WRITE) && wr_ok;
    res.pending_now    = pending_nxt;
    res.busy_now       = busy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initialized_r       <= 1'b0;
      busy_r              <= 1'b0;
      has_data_r          <= 1'b0;
      pending_r           <= 1'b0;
      active_count_r      <= drc_pkg::ACNT_W'(1);
      first_update_time_r <= '0;
      last_update_time_r  <= '0;
      last_refresh_time_r <= '0;
      last_full_time_r    <= '0;
      partial_count_r     <= 8'd0;
    end else if (adv) begin
      initialized_r       <= initialized_nxt;
      busy_r              <= busy_nxt;
      has_data_r          <= has_data_nxt;
      pending_r           <= pending_nxt;
      active_count_r      <= active_count_nxt;
      first_update_time_r <= first_update_time_nxt;
      last_update_time_r  <= last_update_time_nxt;
      last_refresh_time_r <= last_refresh_time_nxt;
      last_full_time_r    <= last_full_time_nxt;
      partial_count_r     <= partial_count_nxt;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (active_count_r != '0) && (active_count_r <= MaxSlotsA))
    else $error("active count out of range");

  a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.issue_refresh |=> busy_r && !initialized_r == 1'b0)
    else $error("issued refresh did not mark busy");

  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.write_accepted |=> has_data_r && pending_r &&
      (last_update_time_r == $past(item.now_ms)))
    else $error("accepted write did not open defer window");

  a_init_clear: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (item.command == drc_pkg::CMD_INIT) |=>
      initialized_r && !busy_r && (partial_count_r == 8'd0))
    else $error("init done not applied");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(pending_r) && $stable(busy_r) && $stable(partial_count_r))
    else $error("state moved without an item");

endmodule

FILE: tb/display_refresh_coalescer_tb.sv
// self-checking testbench for the display refresh coalescer
module display_refresh_coalescer_tb;
  import drc_pkg::*;

  localparam int         SLOT_LIMIT     = MAX_SLOTS_DEF;
  localparam int         HOLD_CYCLES    = 80;
  localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

  // tracks the coalescer's timers and flags and checks each result item in order
  class refresh_scoreboard;
    cfg_t        regs;
    bit          armed, busy, has_data, deferred;
    logic [3:0]  slots;
    logic [31:0] first_upd, last_upd, last_refresh, last_full;
    logic [7:0]  partials;
    result_t     expected_q[$];
    int          errors, items, refreshes, fulls, writes_taken;

    function new();
      regs.quiet_delay_ms   = QUIET_RST;
      regs.max_defer_ms     = MAXDEF_RST;
      regs.min_interval_ms  = MININT_RST;
      regs.partial_limit    = PLIMIT_RST;
      regs.periodic_full_ms = PERIODIC_RST;
      regs.maintenance_ms   = MAINT_RST;
      slots        = 4'd1;
      first_upd    = '0;
      last_upd     = '0;
      last_refresh = '0;
      last_full    = '0;
      partials     = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] data);
      case (idx)
        CFG_QUIET:    regs.quiet_delay_ms   = data;
        CFG_MAXDEF:   regs.max_defer_ms     = data;
        CFG_MININT:   regs.min_interval_ms  = data;
        CFG_PLIMIT:   regs.partial_limit    = data[7:0];
        CFG_PERIODIC: regs.periodic_full_ms = data;
        CFG_MAINT:    regs.maintenance_ms   = data;
        default: ;
      endcase
    endfunction

    // time since stamp, modulo 2^32, has reached span
    function bit gap_reached(logic [31:0] now, logic [31:0] stamp, logic [23:0] span);
      logic [31:0] diff;
      diff = now - stamp;
      return diff >= {8'd0, span};
    endfunction

    function void defer_refresh(logic [31:0] now);
      if (!deferred) first_upd = now;
      last_upd = now;
      deferred = 1'b1;
    endfunction

    function void note_item(item_t it);
      result_t    r;
      logic [7:0] req;
      bit         due;
      r = '0;
      case (it.command)
        CMD_WRITE: begin
          if (it.slot != 8'd0 && it.slot <= {4'd0, slots}) begin
            r.write_accepted = 1'b1;
            has_data = 1'b1;
            defer_refresh(it.now_ms);
          end
        end
        CMD_LAYOUT: begin
          req = it.requested_count;
          if (req < 8'd1) req = 8'd1;
          if (req > 8'(SLOT_LIMIT)) req = 8'(SLOT_LIMIT);
          slots = req[3:0];
          if (has_data) defer_refresh(it.now_ms);
        end
        CMD_TICK: begin
          if (armed && !busy && has_data &&
              gap_reached(it.now_ms, last_refresh, regs.min_interval_ms)) begin
            due = regs.periodic_full_ms != '0 &&
                  gap_reached(it.now_ms, last_full, regs.periodic_full_ms);
            if (deferred) begin
              if (gap_reached(it.now_ms, last_upd, regs.quiet_delay_ms) ||
                  gap_reached(it.now_ms, first_upd, regs.max_defer_ms)) begin
                r.issue_refresh = 1'b1;
                r.issue_full = due || partials >= regs.partial_limit;
                deferred = 1'b0;
              end
            end else if (regs.periodic_full_ms != '0) begin
              if (due) begin
                r.issue_refresh = 1'b1;
                r.issue_full = 1'b1;
              end
            end else if (regs.maintenance_ms != '0 &&
                         gap_reached(it.now_ms, last_refresh, regs.maintenance_ms)) begin
              r.issue_refresh = 1'b1;
              r.issue_full = 1'b1;
            end
            if (r.issue_refresh) busy = 1'b1;
          end
        end
        CMD_INIT: begin
          last_refresh = it.now_ms;
          last_full = it.now_ms;
          partials = '0;
          armed = 1'b1;
          busy = 1'b0;
        end
        CMD_DONE: begin
          last_refresh = it.now_ms;
          if (it.was_full) begin
            last_full = it.now_ms;
            partials = '0;
          end else if (partials != PCOUNT_SAT) begin
            partials = partials + 8'd1;
          end
          busy = 1'b0;
        end
        default: ;
      endcase
      r.pending_now = deferred;
      r.busy_now = busy;
      expected_q.push_back(r);
      items++;
      if (r.issue_refresh) refreshes++;
      if (r.issue_full) fulls++;
      if (r.write_accepted) writes_taken++;
    endfunction

    function void cmp_bit(string field, logic want, logic got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %b actual %b", $time, field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, expected none actual %b", $time, got);
        return;
      end
      want = expected_q.pop_front();
      cmp_bit("issue_refresh", want.issue_refresh, got.issue_refresh);
      cmp_bit("issue_full", want.issue_full, got.issue_full);
      cmp_bit("write_accepted", want.write_accepted, got.write_accepted);
      cmp_bit("pending_now", want.pending_now, got.pending_now);
      cmp_bit("busy_now", want.busy_now, got.busy_now);
    endfunction

    function int waiting();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  drc_in_if  in_ch();
  drc_out_if out_ch();
  drc_cfg_if cfg_ch();

  display_refresh_coalescer DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  refresh_scoreboard sb = new();

  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  int          gen_slots = 1;
  int          reg_writes = 0;
  logic [31:0] clock_ms;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    item_t   seen;
    if (rst_n === 1'b1) begin
      if (out_ch.valid && out_ch.ready) begin
        got.issue_refresh  = out_ch.issue_refresh;
        got.issue_full     = out_ch.issue_full;
        got.write_accepted = out_ch.write_accepted;
        got.pending_now    = out_ch.pending_now;
        got.busy_now       = out_ch.busy_now;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.command         = in_ch.command;
        seen.now_ms          = in_ch.now_ms;
        seen.slot            = in_ch.slot;
        seen.requested_count = in_ch.requested_count;
        seen.was_full        = in_ch.was_full;
        sb.note_item(seen);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.write_reg(cfg_ch.index, cfg_ch.data);
        reg_writes++;
      end
    end
  end

  function automatic item_t mk(logic [2:0] cmd, logic [31:0] at, logic [7:0] s,
                               logic [7:0] rq, logic wf);
    item_t it;
    it.command         = cmd;
    it.now_ms          = at;
    it.slot            = s;
    it.requested_count = rq;
    it.was_full        = wf;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.command         <= it.command;
    in_ch.now_ms          <= it.now_ms;
    in_ch.slot            <= it.slot;
    in_ch.requested_count <= it.requested_count;
    in_ch.was_full        <= it.was_full;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // stop offering items and wait until every result item is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.waiting() != 0);
  endtask

  task automatic set_config(input logic [23:0] quiet, input logic [23:0] maxdef,
                            input logic [23:0] minint, input logic [23:0] plimit,
                            input logic [23:0] periodic, input logic [23:0] maint);
    logic [2:0]  idx[6];
    logic [23:0] val[6];
    idx = '{CFG_QUIET, CFG_MAXDEF, CFG_MININT, CFG_PLIMIT, CFG_PERIODIC, CFG_MAINT};
    val = '{quiet, maxdef, minint, plimit, periodic, maint};
    for (int i = 0; i < 6; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] time_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 32'($urandom_range(0, 2000));
    if (r < 60) return 32'($urandom_range(0, 20000));
    if (r < 85) return 32'($urandom_range(0, 400000));
    if (r < 95) return 32'($urandom_range(0, 24'hFFFFFF));
    return $urandom();  // arbitrary jump, wraps the clock
  endfunction

  task automatic send_random(input int done_pct, input int full_pct, input int init_pct);
    item_t it;
    int    r;
    int    pick;
    clock_ms = clock_ms + time_step();
    it.now_ms = clock_ms;
    it.slot = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(1, gen_slots))
                                           : 8'($urandom_range(0, 255));
    it.requested_count = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 10))
                                                      : 8'($urandom_range(0, 255));
    it.was_full = ($urandom_range(0, 99) < full_pct);
    r = $urandom_range(0, 99);
    if (r < done_pct) begin
      it.command = CMD_DONE;
    end else if (r < done_pct + init_pct) begin
      it.command = CMD_INIT;
    end else if (r < done_pct + init_pct + 3) begin
      it.command = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) it.command = CMD_TICK;
      else if (pick < 88) it.command = CMD_WRITE;
      else it.command = CMD_LAYOUT;
    end
    if (it.command == CMD_LAYOUT) begin
      gen_slots = it.requested_count;
      if (gen_slots < 1) gen_slots = 1;
      if (gen_slots > SLOT_LIMIT) gen_slots = SLOT_LIMIT;
    end
    send_item(it);
  endtask

  task automatic run_random(input int n, input int done_pct, input int full_pct,
                            input int init_pct);
    for (int i = 0; i < n; i++) send_random(done_pct, full_pct, init_pct);
  endtask

  task automatic run_directed();
    logic [31:0] t0;
    t0 = 32'hFFFF_F000;
    send_item(mk(CMD_TICK, t0 - 6000, 8'd1, 8'd1, 1'b0));      // not yet initialized
    send_item(mk(CMD_WRITE, t0 - 6000, 8'd0, 8'd0, 1'b0));     // slot zero rejected
    send_item(mk(CMD_WRITE, t0 - 5900, 8'd1, 8'd0, 1'b1));     // taken before init
    send_item(mk(CMD_WRITE, t0 - 5800, 8'd2, 8'd0, 1'b0));     // above active count
    send_item(mk(CMD_LAYOUT, t0 - 5700, 8'd0, 8'd0, 1'b0));    // clamps up to one
    send_item(mk(CMD_LAYOUT, t0 - 5600, 8'd0, 8'd255, 1'b0));  // clamps down to max
    send_item(mk(CMD_WRITE, t0 - 5500, 8'd8, 8'd0, 1'b0));
    send_item(mk(CMD_WRITE, t0 - 5400, 8'd9, 8'd0, 1'b0));
    send_item(mk(CMD_WRITE, t0 - 5300, 8'd255, 8'd255, 1'b1));
    for (int k = 0; k < 3; k++)
      send_item(mk(CMD_RSVD_FIRST + 3'(k), t0 - 5000, 8'd1, 8'd3, 1'b1));
    send_item(mk(CMD_INIT, t0, 8'd0, 8'd0, 1'b0));
    send_item(mk(CMD_TICK, t0 + 100, 8'd0, 8'd0, 1'b0));       // inside min interval
    send_item(mk(CMD_TICK, t0 + 10000, 8'd0, 8'd0, 1'b0));     // exactly min interval, wraps
    send_item(mk(CMD_TICK, t0 + 30000, 8'd0, 8'd0, 1'b0));     // blocked while busy
    send_item(mk(CMD_DONE, t0 + 31000, 8'd0, 8'd0, 1'b0));
    send_item(mk(CMD_DONE, t0 + 31500, 8'd0, 8'd0, 1'b0));     // done with nothing busy
    send_item(mk(CMD_WRITE, t0 + 32000, 8'd3, 8'd0, 1'b0));
    send_item(mk(CMD_TICK, t0 + 42000, 8'd0, 8'd0, 1'b0));
    send_item(mk(CMD_DONE, t0 + 43000, 8'd0, 8'd0, 1'b1));
    send_item(mk(CMD_INIT, t0 + 50000, 8'd0, 8'd0, 1'b0));     // init again
    send_item(mk(CMD_TICK, t0 + 60000, 8'd0, 8'd0, 1'b0));
    send_item(mk(CMD_TICK, t0 + 410000, 8'd0, 8'd0, 1'b0));    // periodic full due exactly
    send_item(mk(CMD_DONE, t0 + 411000, 8'd0, 8'd0, 1'b1));
    clock_ms = t0 + 412000;
    gen_slots = SLOT_LIMIT;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.now_ms = '0;
    in_ch.slot = '0;
    in_ch.requested_count = '0;
    in_ch.was_full = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_QUIET;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(150, 12, 50, 3);
    drain();

    // all-zero settings: every deferred refresh is full, no idle refresh
    set_config(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    idle_pct = 54;
    run_random(150, 12, 50, 3);
    drain();

    // partial count runs up to saturation, idle refresh on
    set_config(24'hFFFFFF, 24'd2000, 24'd0, 24'd255, 24'd0, 24'd7000);
    idle_pct = 0;
    stall_pct = 54;
    run_random(500, 60, 0, 0);
    drain();

    set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd255, 24'hFFFFFF, 24'hFFFFFF);
    idle_pct = 20;
    stall_pct = 20;
    run_random(150, 12, 50, 3);
    drain();

    // receiver holds off while items keep coming, then mixed idling
    set_config(24'd100, 24'd500, 24'd1000, 24'd2, 24'd50000, 24'd20000);
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    run_random(100, 12, 50, 3);
    idle_pct = 20;
    stall_pct = 20;
    run_random(100, 12, 50, 3);
    drain();
    repeat (4) @(posedge clk);

    $display("checked %0d items across 5 register settings (%0d register writes)",
             sb.items, reg_writes);
    $display("refreshes issued %0d (full %0d), data writes taken %0d",
             sb.refreshes, sb.fulls, sb.writes_taken);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: display_refresh_coalescer.f
hdl/drc_pkg.sv
hdl/drc_if.sv
hdl/drc_cfg.sv
hdl/drc_engine.sv
hdl/display_refresh_coalescer.sv
tb/display_refresh_coalescer_tb.sv
